// ===== rtl/core/i2c_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Shared types, codes and constants for the interrupt-driven I2C transfer
// sequencer and its result queue.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

  // Default width of the byte counter
  localparam int unsigned CountWidthDef = 16;

  // Result queue depth (power of two, at least 4)
  localparam int unsigned ResQDepth = 4;

  // Interrupt enable bit positions
  localparam int unsigned EnEvt = 0;
  localparam int unsigned EnBuf = 1;
  localparam int unsigned EnErr = 2;

  // Error flag bit positions
  localparam int unsigned ErrBus  = 0;
  localparam int unsigned ErrArb  = 1;
  localparam int unsigned ErrAck  = 2;
  localparam int unsigned ErrOvr  = 3;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_MASTER_TX = 3'd0,
    MODE_MEM_TX    = 3'd1,
    MODE_MASTER_RX = 3'd2,
    MODE_MEM_RX    = 3'd3,
    MODE_SLAVE_TX  = 3'd4,
    MODE_SLAVE_RX  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_MASTER_TX = 3'd1,
    ST_MEM_TX    = 3'd2,
    ST_MASTER_RX = 3'd3,
    ST_MEM_RX    = 3'd4,
    ST_SLAVE_TX  = 3'd5,
    ST_SLAVE_RX  = 3'd6
  } xfer_state_e;

  typedef enum logic [2:0] {
    COMP_NONE      = 3'd0,
    COMP_MASTER_TX = 3'd1,
    COMP_MEM_TX    = 3'd2,
    COMP_MASTER_RX = 3'd3,
    COMP_MEM_RX    = 3'd4,
    COMP_SLAVE_RX  = 3'd5,
    COMP_SLAVE_TX  = 3'd6,
    COMP_ERROR     = 3'd7
  } comp_e;

  // Decoded action for one transaction
  typedef enum logic [3:0] {
    ACT_IDLE,
    ACT_START,
    ACT_TX_BUF,
    ACT_TX_BTF,
    ACT_TX_DONE,
    ACT_RX_BYTE,
    ACT_RX_HOLD,
    ACT_RX_DONE,
    ACT_RX_NACK,
    ACT_RX_PAIR,
    ACT_SLV_STOP,
    ACT_SLV_BYTE,
    ACT_ERROR
  } act_e;

  typedef struct packed {
    logic [1:0]  command;
    logic        master_mode;
    logic        transmitter_mode;
    logic        buffer_flag;
    logic        byte_finished;
    logic        address_matched;
    logic        stop_seen;
    logic [3:0]  error_flags;
    logic [7:0]  data_byte;
    logic [7:0]  data_byte_second;
    logic [15:0] start_length;
    logic [2:0]  start_mode;
  } in_item_t;

  typedef struct packed {
    logic        dr_write;
    logic [7:0]  dr_value;
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_value;
    logic        stop_request;
    logic        ack_enabled;
    logic [2:0]  irq_enable_bits;
    logic [2:0]  completion;
    logic [3:0]  error_bits;
    logic [15:0] remaining_count;
    logic        last;
  } out_item_t;

  // Results handed from the sequencer core to the result queue
  typedef struct packed {
    logic      push;
    logic      two;
    out_item_t res_a;
    out_item_t res_b;
  } res_pair_t;

endpackage

// ===== rtl/core/i2c_irq_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C interrupt-driven transfer sequencer
// Top level: input register, sequencer core and result queue.
// ----------------------------------------------------------------------------
// The block takes one transaction (start, event or error snapshot) per cycle
// while the result queue has room. A transaction lands in an input register,
// is evaluated by combinational logic against the transfer state, and its one
// or two results are written into a four-entry result queue, so the first
// result passes the input register and a queue entry before it is presented
// on the output. The input side keeps taking one transaction per cycle as long
// as the queue has room for two results; a two-byte master read or a slave ack
// failure with an error report yields two results, which leave on the output
// channel one after the other. The result queue and the output handshake set
// the sustained rate.
module i2c_irq_transfer_sequencer #(
  parameter int unsigned CountWidth = i2c_seq_pkg::CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i2c_seq_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i2c_seq_pkg::out_item_t out_item_o
);
  import i2c_seq_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  logic      room, fire, in_acc;
  res_pair_t res;

  // Process the held transaction when the queue can take two results
  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vld_d   = in_acc || (in_vld_q && !fire);

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  i2c_seq_ctrl #(
    .CountWidth(CountWidth)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_q),
    .res_o (res)
  );

  i2c_seq_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/core/i2c_seq_ctrl.sv =====
// ----------------------------------------------------------------------------
// I2C sequencer core
// Holds the transfer state and turns one registered transaction into one or
// two results with combinational logic.
// ----------------------------------------------------------------------------
module i2c_seq_ctrl #(
  parameter int unsigned CountWidth = i2c_seq_pkg::CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  i2c_seq_pkg::in_item_t item_i,
  output i2c_seq_pkg::res_pair_t res_o
);
  import i2c_seq_pkg::*;

  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [15:0]           pos_q, pos_d;
  xfer_state_e           st_q, st_d;
  logic [2:0]            en_q, en_d;
  logic                  ack_q, ack_d;
  logic [3:0]            err_q, err_d;

  act_e                  act;
  cmd_e                  cmd;
  logic                  cnt_nz, cnt_gt3, cnt_eq3, cnt_eq2;
  logic [CountWidth-1:0] cnt_dec, cnt_dec2;
  logic [15:0]           pos_inc, pos_inc2;
  logic                  buf_ev, btf_ev;
  logic                  err_en, af_end;
  logic [3:0]            err_mid, err_new;
  comp_e                 comp_tx, comp_rx;
  out_item_t             base, res_a, res_b;
  logic                  two;

  assign cmd      = cmd_e'(item_i.command);
  assign cnt_nz   = |cnt_q;
  assign cnt_gt3  = cnt_q > CountWidth'(3);
  assign cnt_eq3  = cnt_q == CountWidth'(3);
  assign cnt_eq2  = cnt_q == CountWidth'(2);
  assign cnt_dec  = cnt_q - CountWidth'(1);
  assign cnt_dec2 = cnt_q - CountWidth'(2);
  assign pos_inc  = pos_q + 16'd1;
  assign pos_inc2 = pos_q + 16'd2;

  // Qualify flags with the enables
  assign buf_ev = item_i.buffer_flag && en_q[EnBuf] && !item_i.byte_finished;
  assign btf_ev = item_i.byte_finished && en_q[EnEvt];

  assign comp_tx = (st_q == ST_MEM_TX) ? COMP_MEM_TX : COMP_MASTER_TX;
  assign comp_rx = (st_q == ST_MEM_RX) ? COMP_MEM_RX : COMP_MASTER_RX;

  // Slave ack failure at count zero ends a slave transmit
  assign err_en = en_q[EnErr];
  assign af_end = item_i.error_flags[ErrAck] && err_en && !item_i.master_mode &&
                  !cnt_nz && (st_q == ST_SLAVE_TX);
  assign err_mid = err_q | {2'b00,
                            item_i.error_flags[ErrArb] && err_en,
                            item_i.error_flags[ErrBus] && err_en};
  assign err_new = err_mid | {item_i.error_flags[ErrOvr] && err_en && !af_end,
                              item_i.error_flags[ErrAck] && err_en && !af_end,
                              2'b00};

  // Decode the transaction into one action
  always_comb begin
    act = ACT_IDLE;
    unique case (cmd)
      CMD_START: begin
        if (item_i.start_mode <= MODE_SLAVE_RX) act = ACT_START;
      end
      CMD_ERROR: act = ACT_ERROR;
      CMD_EVENT: begin
        if (item_i.master_mode && item_i.transmitter_mode) begin
          if (buf_ev) begin
            act = ACT_TX_BUF;
          end else if (btf_ev) begin
            act = cnt_nz ? ACT_TX_BTF : ACT_TX_DONE;
          end
        end else if (item_i.master_mode) begin
          if (buf_ev) begin
            if (cnt_gt3) act = ACT_RX_BYTE;
            else if (cnt_eq3 || cnt_eq2) act = ACT_RX_HOLD;
            else act = ACT_RX_DONE;
          end else if (btf_ev) begin
            if (cnt_eq3) act = ACT_RX_NACK;
            else if (cnt_eq2) act = ACT_RX_PAIR;
            else if (cnt_nz) act = ACT_RX_BYTE;
          end
        end else if (item_i.address_matched && en_q[EnEvt]) begin
          act = ACT_IDLE;
        end else if (item_i.stop_seen && en_q[EnEvt]) begin
          act = ACT_SLV_STOP;
        end else if ((buf_ev || btf_ev) && cnt_nz) begin
          act = ACT_SLV_BYTE;
        end
      end
      default: act = ACT_IDLE;
    endcase
  end

  // Next state
  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    st_d  = st_q;
    en_d  = en_q;
    ack_d = ack_q;
    err_d = err_q;
    if (fire_i) begin
      unique case (act)
        ACT_START: begin
          cnt_d = CountWidth'(item_i.start_length);
          pos_d = '0;
          st_d  = xfer_state_e'(item_i.start_mode + 3'd1);
          en_d  = 3'b111;
          err_d = '0;
          if (item_i.start_mode >= MODE_MASTER_RX) ack_d = 1'b1;
        end
        ACT_TX_BUF: begin
          if (cnt_nz) begin
            cnt_d = cnt_dec;
            pos_d = pos_inc;
          end
          if (!cnt_nz || (cnt_dec == '0)) en_d[EnBuf] = 1'b0;
        end
        ACT_TX_BTF, ACT_RX_BYTE, ACT_SLV_BYTE: begin
          cnt_d = cnt_dec;
          pos_d = pos_inc;
        end
        ACT_TX_DONE: begin
          en_d = '0;
          st_d = ST_READY;
        end
        ACT_RX_HOLD: en_d[EnBuf] = 1'b0;
        ACT_RX_DONE: begin
          en_d = '0;
          st_d = ST_READY;
          if (cnt_nz) begin
            cnt_d = cnt_dec;
            pos_d = pos_inc;
          end
        end
        ACT_RX_NACK: begin
          ack_d = 1'b0;
          cnt_d = cnt_dec;
          pos_d = pos_inc;
        end
        ACT_RX_PAIR: begin
          cnt_d = cnt_dec2;
          pos_d = pos_inc2;
          en_d  = en_q & (3'b001 << EnBuf);
          st_d  = ST_READY;
        end
        ACT_SLV_STOP: begin
          en_d  = '0;
          ack_d = 1'b0;
          st_d  = ST_READY;
        end
        ACT_ERROR: begin
          err_d = err_new;
          if (af_end) begin
            en_d  = '0;
            ack_d = 1'b0;
            st_d  = ST_READY;
          end
          if (err_new != '0) st_d = ST_READY;
        end
        default: ;
      endcase
    end
  end

  // Build the results from the updated state
  always_comb begin
    base                 = '0;
    base.store_index     = pos_q;
    base.ack_enabled     = ack_d;
    base.irq_enable_bits = en_d;
    base.error_bits      = err_d;
    base.remaining_count = 16'(cnt_d);
    base.last            = 1'b1;
    base.completion      = COMP_NONE;
    res_a = base;
    res_b = base;
    two   = 1'b0;
    unique case (act)
      ACT_START: res_a.store_index = '0;
      ACT_TX_BUF: begin
        res_a.dr_write = cnt_nz;
        res_a.dr_value = cnt_nz ? item_i.data_byte : 8'd0;
      end
      ACT_TX_BTF: begin
        res_a.dr_write = 1'b1;
        res_a.dr_value = item_i.data_byte;
      end
      ACT_TX_DONE: begin
        res_a.stop_request = 1'b1;
        res_a.completion   = comp_tx;
      end
      ACT_RX_BYTE, ACT_RX_NACK: begin
        res_a.store_valid = 1'b1;
        res_a.store_value = item_i.data_byte;
      end
      ACT_RX_DONE: begin
        res_a.store_valid = cnt_nz;
        res_a.store_value = cnt_nz ? item_i.data_byte : 8'd0;
        res_a.completion  = comp_rx;
      end
      ACT_RX_PAIR: begin
        two                   = 1'b1;
        res_a.store_valid     = 1'b1;
        res_a.store_value     = item_i.data_byte;
        res_a.stop_request    = 1'b1;
        res_a.ack_enabled     = ack_q;
        res_a.irq_enable_bits = en_q;
        res_a.error_bits      = err_q;
        res_a.remaining_count = 16'(cnt_dec);
        res_a.last            = 1'b0;
        res_b.store_valid     = 1'b1;
        res_b.store_index     = pos_inc;
        res_b.store_value     = item_i.data_byte_second;
        res_b.completion      = comp_rx;
      end
      ACT_SLV_STOP: res_a.completion = COMP_SLAVE_RX;
      ACT_SLV_BYTE: begin
        if (item_i.transmitter_mode) begin
          res_a.dr_write = 1'b1;
          res_a.dr_value = item_i.data_byte;
        end else begin
          res_a.store_valid = 1'b1;
          res_a.store_value = item_i.data_byte;
        end
      end
      ACT_ERROR: begin
        if (af_end) begin
          res_a.completion = COMP_SLAVE_TX;
          res_a.error_bits = err_mid;
          if (err_new != '0) begin
            two              = 1'b1;
            res_a.last       = 1'b0;
            res_b.completion = COMP_ERROR;
          end
        end else if (err_new != '0) begin
          res_a.completion = COMP_ERROR;
        end
      end
      default: ;
    endcase
  end

  assign res_o = '{push: fire_i, two: two, res_a: res_a, res_b: res_b};

  // Hold the transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      st_q  <= ST_READY;
      en_q  <= '0;
      ack_q <= 1'b0;
      err_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      st_q  <= st_d;
      en_q  <= en_d;
      ack_q <= ack_d;
      err_q <= err_d;
    end
  end

endmodule

// ===== rtl/core/i2c_seq_resq.sv =====
// ----------------------------------------------------------------------------
// I2C sequencer result queue
// Small queue that takes one or two results per cycle and delivers one per
// cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module i2c_seq_resq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2c_seq_pkg::res_pair_t res_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i2c_seq_pkg::out_item_t out_item_o
);
  import i2c_seq_pkg::*;

  localparam int unsigned PtrW = $clog2(ResQDepth);
  localparam int unsigned CntW = $clog2(ResQDepth + 1);

  out_item_t           mem_q [ResQDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop, push_b;

  assign push_b      = res_i.push && res_i.two;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room_o      = cnt_q <= CntW'(ResQDepth - 2);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(res_i.push) + PtrW'(push_b);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(res_i.push) + CntW'(push_b) - CntW'(pop);
  end

  // Write results
  always_ff @(posedge clk_i) begin
    if (res_i.push) mem_q[wr_ptr_q] <= res_i.res_a;
    if (push_b) mem_q[wr_ptr_q + PtrW'(1)] <= res_i.res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/i2c_seq_checker.sv =====
// ----------------------------------------------------------------------------
// I2C sequencer port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module i2c_seq_assert (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input i2c_seq_pkg::out_item_t out_item_o
);
  import i2c_seq_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Never write and store in one result
  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.dr_write && out_item_o.store_valid))
    else $error("result both writes and stores a byte");

  // A non-final result is the first of a byte pair or a slave transmit end
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |->
      (out_item_o.stop_request && out_item_o.store_valid) ||
      (out_item_o.completion == COMP_SLAVE_TX))
    else $error("unexpected non-final result");

  // Drop all enables on a full completion
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.completion == COMP_MASTER_TX) ||
                    (out_item_o.completion == COMP_MEM_TX) ||
                    (out_item_o.completion == COMP_SLAVE_RX) ||
                    (out_item_o.completion == COMP_SLAVE_TX)) |->
      out_item_o.irq_enable_bits == 3'b000)
    else $error("enables left set after completion");

  // Nothing comes out of an idle block right after reset
  a_no_early: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result before any transaction");

endmodule

bind i2c_irq_transfer_sequencer i2c_seq_assert u_i2c_seq_assert (.*);

// ===== sim/i2c_seq_checker.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer checker
// Watches both channels of the sequencer. It keeps its own copy of the
// transfer state, works out the results of every accepted transaction, and
// compares each result that leaves the block against the oldest one awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_seq_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  i2c_seq_pkg::in_item_t  in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  i2c_seq_pkg::out_item_t out_item_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            awaited_count_o
);
  import i2c_seq_pkg::*;

  // Shadow copy of the transfer state
  logic [15:0] bytes_left_q;
  logic [15:0] position_q;
  xfer_state_e xfer_q;
  logic [2:0]  irq_en_q;
  logic        ack_q;
  logic [3:0]  err_q;

  out_item_t awaited_results[$];

  // Build a result from the given byte movement and the current state
  function automatic out_item_t make_result(input logic dw, input logic [7:0] dv,
                                            input logic sv, input logic [15:0] idx,
                                            input logic [7:0] val, input logic stp,
                                            input comp_e comp, input logic lst);
    out_item_t r;
    r.dr_write        = dw;
    r.dr_value        = dv;
    r.store_valid     = sv;
    r.store_index     = idx;
    r.store_value     = val;
    r.stop_request    = stp;
    r.ack_enabled     = ack_q;
    r.irq_enable_bits = irq_en_q;
    r.completion      = comp;
    r.error_bits      = err_q;
    r.remaining_count = bytes_left_q;
    r.last            = lst;
    return r;
  endfunction

  // Step the buffer position; count down, but never below zero
  function automatic logic [15:0] take_position();
    logic [15:0] p;
    p = position_q;
    position_q = position_q + 16'd1;
    if (bytes_left_q != '0) begin
      bytes_left_q = bytes_left_q - 16'd1;
    end
    return p;
  endfunction

  function automatic comp_e rx_done_kind();
    if (xfer_q == ST_MEM_RX) begin
      return COMP_MEM_RX;
    end
    return COMP_MASTER_RX;
  endfunction

  // Update the shadow state for one transaction and queue its results
  task automatic apply_transaction(input in_item_t it);
    logic        dw, sv, stp, evt, ben, bufev, btfev, slave_end;
    logic [7:0]  dv, val;
    logic [15:0] idx;
    comp_e       comp;
    out_item_t   first;
    dw = 1'b0; dv = '0; sv = 1'b0; val = '0; stp = 1'b0;
    comp = COMP_NONE;
    idx = position_q;
    slave_end = 1'b0;
    first = '0;
    evt = irq_en_q[EnEvt];
    ben = irq_en_q[EnBuf];
    bufev = it.buffer_flag && ben && !it.byte_finished;
    btfev = it.byte_finished && evt;
    case (it.command)
      CMD_START: begin
        if (it.start_mode <= MODE_SLAVE_RX) begin
          bytes_left_q = it.start_length;
          position_q = '0;
          xfer_q = xfer_state_e'(it.start_mode + 3'd1);
          irq_en_q = '1;
          err_q = '0;
          if (it.start_mode >= MODE_MASTER_RX) begin
            ack_q = 1'b1;
          end
          idx = '0;
        end
      end
      CMD_EVENT: begin
        if (it.master_mode && it.transmitter_mode) begin
          // Master transmit: feed the data register, finish on BTF at zero
          if (bufev) begin
            if (bytes_left_q != '0) begin
              dw = 1'b1; dv = it.data_byte; idx = take_position();
            end
            if (bytes_left_q == '0) begin
              irq_en_q[EnBuf] = 1'b0;
            end
          end else if (btfev) begin
            if (bytes_left_q != '0) begin
              dw = 1'b1; dv = it.data_byte; idx = take_position();
            end else begin
              irq_en_q = '0;
              stp = 1'b1;
              comp = (xfer_q == ST_MEM_TX) ? COMP_MEM_TX : COMP_MASTER_TX;
              xfer_q = ST_READY;
            end
          end
        end else if (it.master_mode) begin
          // Master receive: last three bytes go through BTF
          if (bufev) begin
            if (bytes_left_q > 16'd3) begin
              sv = 1'b1; val = it.data_byte; idx = take_position();
            end else if (bytes_left_q >= 16'd2) begin
              irq_en_q[EnBuf] = 1'b0;
            end else begin
              irq_en_q = '0;
              if (bytes_left_q != '0) begin
                sv = 1'b1; val = it.data_byte; idx = take_position();
              end
              comp = rx_done_kind();
              xfer_q = ST_READY;
            end
          end else if (btfev) begin
            if (bytes_left_q == 16'd3) begin
              ack_q = 1'b0;
              sv = 1'b1; val = it.data_byte; idx = take_position();
            end else if (bytes_left_q == 16'd2) begin
              // Two bytes at once: STOP with the first, completion with the second
              idx = take_position();
              awaited_results.push_back(make_result(1'b0, '0, 1'b1, idx, it.data_byte,
                                                    1'b1, COMP_NONE, 1'b0));
              idx = take_position();
              irq_en_q[EnEvt] = 1'b0;
              irq_en_q[EnErr] = 1'b0;
              comp = rx_done_kind();
              xfer_q = ST_READY;
              awaited_results.push_back(make_result(1'b0, '0, 1'b1, idx,
                                                    it.data_byte_second, 1'b0, comp, 1'b1));
              return;
            end else if (bytes_left_q != '0) begin
              sv = 1'b1; val = it.data_byte; idx = take_position();
            end
          end
        end else if (it.address_matched && evt) begin
          // Address match is only acknowledged
        end else if (it.stop_seen && evt) begin
          irq_en_q = '0;
          ack_q = 1'b0;
          xfer_q = ST_READY;
          comp = COMP_SLAVE_RX;
        end else if (bufev || btfev) begin
          if (bytes_left_q != '0) begin
            if (it.transmitter_mode) begin
              dw = 1'b1; dv = it.data_byte;
            end else begin
              sv = 1'b1; val = it.data_byte;
            end
            idx = take_position();
          end
        end
      end
      CMD_ERROR: begin
        if (it.error_flags[ErrBus] && irq_en_q[EnErr]) begin
          err_q[ErrBus] = 1'b1;
        end
        if (it.error_flags[ErrArb] && irq_en_q[EnErr]) begin
          err_q[ErrArb] = 1'b1;
        end
        if (it.error_flags[ErrAck] && irq_en_q[EnErr]) begin
          // Slave transmit ends on the NACK of its last byte
          if (!it.master_mode && bytes_left_q == '0 && xfer_q == ST_SLAVE_TX) begin
            irq_en_q = '0;
            ack_q = 1'b0;
            xfer_q = ST_READY;
            first = make_result(1'b0, '0, 1'b0, position_q, '0, 1'b0, COMP_SLAVE_TX, 1'b0);
            slave_end = 1'b1;
          end else begin
            err_q[ErrAck] = 1'b1;
          end
        end
        if (it.error_flags[ErrOvr] && irq_en_q[EnErr]) begin
          err_q[ErrOvr] = 1'b1;
        end
        if (err_q != '0) begin
          xfer_q = ST_READY;
          comp = COMP_ERROR;
          if (slave_end) begin
            awaited_results.push_back(first);
          end
        end else if (slave_end) begin
          first.last = 1'b1;
          awaited_results.push_back(first);
          return;
        end
      end
      default: ;
    endcase
    awaited_results.push_back(make_result(dw, dv, sv, idx, val, stp, comp, 1'b1));
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  // Compare one result with the oldest one awaited
  task automatic compare_result(input out_item_t act);
    out_item_t exp_r;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, act);
      mismatch_count_o++;
    end else begin
      exp_r = awaited_results.pop_front();
      check_field("dr_write", 16'(exp_r.dr_write), 16'(act.dr_write));
      check_field("dr_value", 16'(exp_r.dr_value), 16'(act.dr_value));
      check_field("store_valid", 16'(exp_r.store_valid), 16'(act.store_valid));
      check_field("store_index", exp_r.store_index, act.store_index);
      check_field("store_value", 16'(exp_r.store_value), 16'(act.store_value));
      check_field("stop_request", 16'(exp_r.stop_request), 16'(act.stop_request));
      check_field("ack_enabled", 16'(exp_r.ack_enabled), 16'(act.ack_enabled));
      check_field("irq_enable_bits", 16'(exp_r.irq_enable_bits),
                  16'(act.irq_enable_bits));
      check_field("completion", 16'(exp_r.completion), 16'(act.completion));
      check_field("error_bits", 16'(exp_r.error_bits), 16'(act.error_bits));
      check_field("remaining_count", exp_r.remaining_count, act.remaining_count);
      check_field("last", 16'(exp_r.last), 16'(act.last));
    end
  endtask

  // Track inputs first, then compare outputs, at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q = '0;
      position_q = '0;
      xfer_q = ST_READY;
      irq_en_q = '0;
      ack_q = 1'b0;
      err_q = '0;
      awaited_results.delete();
      mismatch_count_o = 0;
      awaited_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        apply_transaction(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        compare_result(out_item_i);
      end
      awaited_count_o = awaited_results.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer testbench
// Drives directed corner transactions and then random, mostly well-formed
// transfers in every mode into the sequencer, with bursty input and a
// stalling receiver. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import i2c_seq_pkg::*;

  localparam logic [1:0] CmdUndef = 2'd3;
  localparam int unsigned ItemTarget = 900;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_MASK,
    STALL_HEAVY
  } stall_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned sent;
  int unsigned burst_left;

  i2c_irq_transfer_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  i2c_seq_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t random_item();
    logic [63:0] b;
    b = {$urandom, $urandom};
    return b[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t start_item(input logic [15:0] len, input logic [2:0] mode);
    in_item_t it;
    it = random_item();
    it.command = CMD_START;
    it.start_length = len;
    it.start_mode = mode;
    return it;
  endfunction

  function automatic in_item_t event_item(input logic msl, input logic tra,
                                          input logic bflag, input logic btf,
                                          input logic addr, input logic stopf);
    in_item_t it;
    it = random_item();
    it.command = CMD_EVENT;
    it.master_mode = msl;
    it.transmitter_mode = tra;
    it.buffer_flag = bflag;
    it.byte_finished = btf;
    it.address_matched = addr;
    it.stop_seen = stopf;
    return it;
  endfunction

  function automatic in_item_t error_item(input logic msl, input logic [3:0] flags);
    in_item_t it;
    it = random_item();
    it.command = CMD_ERROR;
    it.master_mode = msl;
    it.error_flags = flags;
    return it;
  endfunction

  // Send one transaction; open a new burst after a random gap when due
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
        in_item = random_item();
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // One transfer: start, a run of mostly mode-matched events, then its normal ending
  task automatic run_transfer();
    mode_e       mode;
    logic [15:0] len;
    int unsigned steps;
    int unsigned pick;
    logic        tra;
    logic        is_master;
    logic        btf;
    logic [3:0]  flags;
    mode = mode_e'($urandom_range(MODE_MASTER_TX, MODE_SLAVE_RX));
    case ($urandom_range(0, 9))
      0:       len = 16'($urandom);
      1, 2:    len = 16'($urandom_range(9, 40));
      default: len = 16'($urandom_range(0, 8));
    endcase
    steps = (len > 16'd40) ? $urandom_range(5, 40) : len + $urandom_range(1, 4);
    is_master = (mode <= MODE_MEM_RX);
    tra = (mode == MODE_MASTER_TX || mode == MODE_MEM_TX || mode == MODE_SLAVE_TX);
    send_item(start_item(len, mode));
    if (!is_master) begin
      send_item(event_item(1'b0, tra, 1'($urandom), 1'($urandom), 1'b1, 1'($urandom)));
    end
    for (int unsigned i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(error_item(1'($urandom), 4'($urandom)));
      end else if (pick < 8) begin
        send_item(random_item());
      end else begin
        // Lean toward BTF near the end of the count
        if (i + 3 >= len) begin
          btf = ($urandom_range(0, 9) < 7);
        end else begin
          btf = ($urandom_range(0, 9) == 0);
        end
        send_item(event_item(is_master, tra, $urandom_range(0, 7) != 0, btf, 1'b0, 1'b0));
      end
    end
    if (!is_master && tra) begin
      flags = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b0;
      flags[ErrAck] = 1'b1;
      send_item(error_item(1'b0, flags));
    end else if (!is_master) begin
      send_item(event_item(1'b0, 1'b0, 1'($urandom), 1'($urandom), 1'b0, 1'b1));
    end else if (tra) begin
      send_item(event_item(1'b1, 1'b1, 1'($urandom), 1'b1, 1'b0, 1'b0));
    end
  endtask

  // Receiver: pick a new random stall style at the end of each phase
  initial begin
    stall_e      stall_mode;
    int unsigned phase_left;
    logic [15:0] mask;
    out_ready = 1'b0;
    stall_mode = STALL_NONE;
    phase_left = 0;
    mask = '1;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        stall_mode = stall_e'($urandom_range(STALL_NONE, STALL_HEAVY));
        mask = 16'($urandom);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (stall_mode)
        STALL_NONE: out_ready = 1'b1;
        STALL_COIN: out_ready = 1'($urandom_range(0, 1));
        STALL_MASK: begin
          out_ready = mask[0];
          mask = {mask[0], mask[15:1]};
        end
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stimulus and verdict
  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Undefined command and undefined start mode
    it = random_item();
    it.command = CmdUndef;
    send_item(it);
    send_item(start_item(16'hFFFF, 3'($urandom_range(6, 7))));
    // Events and errors with all enables clear
    send_item(error_item(1'b1, 4'hF));
    send_item(event_item(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    // Memory transmit of zero bytes: TXE at zero, then BTF completes
    send_item(start_item(16'd0, MODE_MEM_TX));
    send_item(event_item(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(event_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    // Master transmit of one byte
    send_item(start_item(16'd1, MODE_MASTER_TX));
    it = event_item(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    it.data_byte = 8'hFF;
    send_item(it);
    send_item(event_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    // Master receive of four bytes: hold at three, NACK, two-byte read
    send_item(start_item(16'd4, MODE_MASTER_RX));
    send_item(event_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(event_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(event_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    it = event_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    it.data_byte = 8'h00;
    it.data_byte_second = 8'hFF;
    send_item(it);
    // Memory receive at zero: BTF stores nothing, RXNE completes
    send_item(start_item(16'd0, MODE_MEM_RX));
    send_item(event_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(event_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    // Slave transmit NACK at zero together with an error report
    send_item(start_item(16'd0, MODE_SLAVE_TX));
    send_item(error_item(1'b0, 4'hF));
    // Slave receive interrupted by a new start, then arbitration loss
    send_item(start_item(16'd2, MODE_SLAVE_RX));
    send_item(event_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(event_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(start_item(16'hFFFF, MODE_MASTER_TX));
    send_item(error_item(1'b1, 4'(1 << ErrArb)));
    // Slave receive ended by STOP
    send_item(start_item(16'd1, MODE_SLAVE_RX));
    send_item(event_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));

    // Random transfers with some noise
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(random_item());
      end else begin
        run_transfer();
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then wait for stray results
    while (awaited != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
